@@ design/zblf_pkg.sv @@
// ----------------------------------------------------------------------------
// zblf_pkg
// Shared types, register map, reset values and constants of the depth-tested
// Lambert fill unit.
// ----------------------------------------------------------------------------
package zblf_pkg;

  localparam int DEF_MAX_GRID_WIDTH  = 128;
  localparam int DEF_MAX_GRID_HEIGHT = 128;
  localparam int DEF_RECT_W          = 4;
  localparam int DEF_RECT_H          = 4;

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 48;

  localparam int DEPTH_W    = 16;
  localparam int CELL_IDX_W = 15;

  localparam logic [DEPTH_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [31:0]        BRIGHT_MIN = 32'd26843546;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_FRAG  = 1'b1;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_LIGHT_DIR_X = 3'd2,
    REG_LIGHT_DIR_Y = 3'd3,
    REG_LIGHT_DIR_Z = 3'd4,
    REG_LIGHT_RED   = 3'd5,
    REG_LIGHT_GREEN = 3'd6,
    REG_LIGHT_BLUE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [7:0]  grid_width;
    logic        [7:0]  grid_height;
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
    logic        [9:0]  light_red;
    logic        [9:0]  light_green;
    logic        [9:0]  light_blue;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    grid_width:  8'd128,
    grid_height: 8'd128,
    light_dir_x: 16'sd0,
    light_dir_y: 16'sd0,
    light_dir_z: 16'sd16384,
    light_red:   10'd256,
    light_green: 10'd256,
    light_blue:  10'd256
  };

  typedef struct packed {
    logic                    is_clear;
    logic [CELL_IDX_W-1:0]   cell_idx;
    logic [6:0]              cell_x;
    logic [6:0]              cell_y;
    logic [DEPTH_W-1:0]      depth;
    logic signed [15:0]      normal_x;
    logic signed [15:0]      normal_y;
    logic signed [15:0]      normal_z;
    logic [7:0]              albedo_red;
    logic [7:0]              albedo_green;
    logic [7:0]              albedo_blue;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

@@ design/zbuffer_lambert_block_fill_unit.sv @@
// ----------------------------------------------------------------------------
// zbuffer_lambert_block_fill_unit
// Depth-tested Lambert fill for coarse cells. After reset the depth store
// (MAX_GRID_WIDTH * MAX_GRID_HEIGHT entries, 16384 by default) is swept to
// full scale at one entry per cycle, and in_tready stays low during the
// sweep; a clear word runs the same sweep. A fragment outside the grid or
// with negative depth is taken and dropped. A fragment that reaches the back
// has its store entry read in S_IDLE and its depth tested in S_TEST; if it
// passes, S_DOT, S_SCALE, S_LIGHT and S_SAT work out the colour and then
// RECT_W * RECT_H pixel words leave at one per cycle while the output does
// not stall. A two-entry queue lets the input side keep taking words while
// the back works, and an output register holds a pixel while out_tready is
// low.
// ----------------------------------------------------------------------------
module zbuffer_lambert_block_fill_unit #(
  parameter int MAX_GRID_WIDTH  = zblf_pkg::DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = zblf_pkg::DEF_MAX_GRID_HEIGHT,
  parameter int RECT_W          = zblf_pkg::DEF_RECT_W,
  parameter int RECT_H          = zblf_pkg::DEF_RECT_H
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cell_x, cell_y, depth, normal_x, normal_y, normal_z,
  // albedo_red, albedo_green, albedo_blue, zero fill
  input  logic [zblf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_x, pixel_y, red, green, blue, zero fill
  output logic [zblf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [zblf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [zblf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [zblf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  import zblf_pkg::*;

  cfg_t         cfg;
  back_status_t status;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  q_entry_t     q_data;
  q_entry_t     q_head;
  logic [9:0]   pixel_x;
  logic [9:0]   pixel_y;
  logic [7:0]   red;
  logic [7:0]   green;
  logic [7:0]   blue;

  zblf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  zblf_front #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .status    (status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  zblf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  zblf_back #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
    .RECT_W          (RECT_W),
    .RECT_H          (RECT_H)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_pixel_x (pixel_x),
    .out_pixel_y (pixel_y),
    .out_red     (red),
    .out_green   (green),
    .out_blue    (blue),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'd0, blue, green, red, pixel_y, pixel_x};

endmodule

@@ design/zblf_ram.sv @@
// ----------------------------------------------------------------------------
// zblf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module zblf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/zblf_regs.sv @@
// ----------------------------------------------------------------------------
// zblf_regs
// APB-style register file holding grid size, light direction and strengths.
// ----------------------------------------------------------------------------
module zblf_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [zblf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [zblf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [zblf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output zblf_pkg::cfg_t                      cfg
);

  import zblf_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_GRID_WIDTH:  cfg_nxt.grid_width  = cfg_pwdata[7:0];
        REG_GRID_HEIGHT: cfg_nxt.grid_height = cfg_pwdata[7:0];
        REG_LIGHT_DIR_X: cfg_nxt.light_dir_x = cfg_pwdata[15:0];
        REG_LIGHT_DIR_Y: cfg_nxt.light_dir_y = cfg_pwdata[15:0];
        REG_LIGHT_DIR_Z: cfg_nxt.light_dir_z = cfg_pwdata[15:0];
        REG_LIGHT_RED:   cfg_nxt.light_red   = cfg_pwdata[9:0];
        REG_LIGHT_GREEN: cfg_nxt.light_green = cfg_pwdata[9:0];
        REG_LIGHT_BLUE:  cfg_nxt.light_blue  = cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_WIDTH:  cfg_prdata = {24'd0, cfg_r.grid_width};
      REG_GRID_HEIGHT: cfg_prdata = {24'd0, cfg_r.grid_height};
      REG_LIGHT_DIR_X: cfg_prdata = {16'd0, cfg_r.light_dir_x};
      REG_LIGHT_DIR_Y: cfg_prdata = {16'd0, cfg_r.light_dir_y};
      REG_LIGHT_DIR_Z: cfg_prdata = {16'd0, cfg_r.light_dir_z};
      REG_LIGHT_RED:   cfg_prdata = {22'd0, cfg_r.light_red};
      REG_LIGHT_GREEN: cfg_prdata = {22'd0, cfg_r.light_green};
      REG_LIGHT_BLUE:  cfg_prdata = {22'd0, cfg_r.light_blue};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/zblf_queue.sv @@
// ----------------------------------------------------------------------------
// zblf_queue
// Short register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module zblf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  zblf_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output zblf_pkg::q_entry_t  head,
  output logic                empty
);

  import zblf_pkg::*;

  q_entry_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/zblf_front.sv @@
// ----------------------------------------------------------------------------
// zblf_front
// Accepts input words, drops fragments outside the grid or with negative
// depth, computes the cell index and queues clears and surviving fragments.
// ----------------------------------------------------------------------------
module zblf_front #(
  parameter int MAX_GRID_WIDTH  = zblf_pkg::DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = zblf_pkg::DEF_MAX_GRID_HEIGHT
) (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [zblf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  zblf_pkg::cfg_t                      cfg,
  input  zblf_pkg::back_status_t              status,
  input  logic                                q_full,
  output logic                                q_push,
  output zblf_pkg::q_entry_t                  q_data
);

  import zblf_pkg::*;

  logic [7:0]  cell_x;
  logic [7:0]  cell_y;
  logic [16:0] depth;
  logic [7:0]  gw;
  logic [7:0]  gh;
  logic        in_range;
  logic [15:0] idx_w;

  assign cell_x = in_tdata[7:0];
  assign cell_y = in_tdata[15:8];
  assign depth  = in_tdata[32:16];

  // The active grid never exceeds the size of the depth store.
  assign gw = (int'(cfg.grid_width) > MAX_GRID_WIDTH) ? 8'(MAX_GRID_WIDTH) : cfg.grid_width;
  assign gh = (int'(cfg.grid_height) > MAX_GRID_HEIGHT) ? 8'(MAX_GRID_HEIGHT) :
              cfg.grid_height;

  assign in_range = !cell_x[7] && !cell_y[7] && !depth[16] &&
                    ({1'b0, cell_x[6:0]} < gw) && ({1'b0, cell_y[6:0]} < gh);

  assign idx_w = 16'(cell_y[6:0]) * 16'(gw) + 16'(cell_x[6:0]);

  assign in_tready = !q_full && !status.clearing;
  assign q_push    = in_tvalid && in_tready && ((in_tuser == KIND_CLEAR) || in_range);

  always_comb begin
    q_data.is_clear     = (in_tuser == KIND_CLEAR);
    q_data.cell_idx     = idx_w[CELL_IDX_W-1:0];
    q_data.cell_x       = cell_x[6:0];
    q_data.cell_y       = cell_y[6:0];
    q_data.depth        = depth[DEPTH_W-1:0];
    q_data.normal_x     = in_tdata[48:33];
    q_data.normal_y     = in_tdata[64:49];
    q_data.normal_z     = in_tdata[80:65];
    q_data.albedo_red   = in_tdata[88:81];
    q_data.albedo_green = in_tdata[96:89];
    q_data.albedo_blue  = in_tdata[104:97];
  end

endmodule

@@ design/zblf_back.sv @@
// ----------------------------------------------------------------------------
// zblf_back
// Clears the depth store, runs the depth test, shades passing fragments
// through a multiply pipeline and streams the pixel block to the output.
// ----------------------------------------------------------------------------
module zblf_back #(
  parameter int MAX_GRID_WIDTH  = zblf_pkg::DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = zblf_pkg::DEF_MAX_GRID_HEIGHT,
  parameter int RECT_W          = zblf_pkg::DEF_RECT_W,
  parameter int RECT_H          = zblf_pkg::DEF_RECT_H
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  zblf_pkg::cfg_t          cfg,
  input  logic                    q_empty,
  input  zblf_pkg::q_entry_t      q_head,
  output logic                    q_pop,
  output zblf_pkg::back_status_t  status,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [9:0]              out_pixel_x,
  output logic [9:0]              out_pixel_y,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_last
);

  import zblf_pkg::*;

  localparam int STORE_SIZE = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int COL_W      = (RECT_W > 1) ? $clog2(RECT_W) : 1;
  localparam int ROW_W      = (RECT_H > 1) ? $clog2(RECT_H) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TEST, S_DOT, S_SCALE, S_LIGHT, S_SAT, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  q_entry_t            item_r, item_nxt;
  logic signed [31:0]  prod_r [3];
  logic signed [31:0]  prod_nxt [3];
  logic [31:0]         bright_r, bright_nxt;
  logic [39:0]         ab_r [3];
  logic [39:0]         ab_nxt [3];
  logic [49:0]         lp_r [3];
  logic [49:0]         lp_nxt [3];
  logic [7:0]          shade_r [3];
  logic [7:0]          shade_nxt [3];
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [9:0]          out_px_r, out_px_nxt;
  logic [9:0]          out_py_r, out_py_nxt;
  logic [7:0]          out_color_r [3];
  logic [7:0]          out_color_nxt [3];
  logic                out_last_r, out_last_nxt;

  logic signed [15:0]  nrm [3];
  logic signed [15:0]  lgt [3];
  logic [7:0]          alb [3];
  logic [9:0]          str [3];
  logic signed [33:0]  dot;
  logic signed [33:0]  neg;
  logic                load;
  logic                last_pix;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DEPTH_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DEPTH_W-1:0]  ram_rdata;

  zblf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    nrm[0] = item_r.normal_x;
    nrm[1] = item_r.normal_y;
    nrm[2] = item_r.normal_z;
    lgt[0] = cfg.light_dir_x;
    lgt[1] = cfg.light_dir_y;
    lgt[2] = cfg.light_dir_z;
    alb[0] = item_r.albedo_red;
    alb[1] = item_r.albedo_green;
    alb[2] = item_r.albedo_blue;
    str[0] = cfg.light_red;
    str[1] = cfg.light_green;
    str[2] = cfg.light_blue;
  end

  assign dot      = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]);
  assign neg      = -dot;
  assign last_pix = (col_r == COL_W'(RECT_W - 1)) && (row_r == ROW_W'(RECT_H - 1));

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    addr_nxt      = addr_r;
    item_nxt      = item_r;
    bright_nxt    = bright_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i]      = prod_r[i];
      ab_nxt[i]        = ab_r[i];
      lp_nxt[i]        = lp_r[i];
      shade_nxt[i]     = shade_r[i];
      out_color_nxt[i] = out_color_r[i];
    end
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = FULL_SCALE;
    ram_re    = 1'b0;
    ram_raddr = AW'(q_head.cell_idx);
    load      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == AW'(STORE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          addr_nxt = AW'(q_head.cell_idx);
          if (q_head.is_clear) begin
            clr_addr_nxt = '0;
            state_nxt    = S_CLEAR;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        for (int i = 0; i < 3; i++) begin
          prod_nxt[i] = nrm[i] * lgt[i];
        end
        if (item_r.depth < ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = addr_r;
          ram_wdata = item_r.depth;
          state_nxt = S_DOT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DOT: begin
        bright_nxt = (neg < $signed({2'b00, BRIGHT_MIN})) ? BRIGHT_MIN : neg[31:0];
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ab_nxt[i] = 40'(alb[i]) * 40'(bright_r);
        end
        state_nxt = S_LIGHT;
      end
      S_LIGHT: begin
        for (int i = 0; i < 3; i++) begin
          lp_nxt[i] = 50'(ab_r[i]) * 50'(str[i]);
        end
        state_nxt = S_SAT;
      end
      S_SAT: begin
        for (int i = 0; i < 3; i++) begin
          shade_nxt[i] = (lp_r[i][49:36] > 14'd255) ? 8'hFF : lp_r[i][43:36];
        end
        col_nxt   = '0;
        row_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load         = 1'b1;
          out_px_nxt   = 10'(int'(item_r.cell_x) * RECT_W + int'(col_r));
          out_py_nxt   = 10'(int'(item_r.cell_y) * RECT_H + int'(row_r));
          out_last_nxt = last_pix;
          for (int i = 0; i < 3; i++) begin
            out_color_nxt[i] = shade_r[i];
          end
          if (last_pix) begin
            state_nxt = S_IDLE;
          end else if (col_r == COL_W'(RECT_W - 1)) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    item_r     <= item_nxt;
    bright_r   <= bright_nxt;
    out_px_r   <= out_px_nxt;
    out_py_r   <= out_py_nxt;
    out_last_r <= out_last_nxt;
    for (int i = 0; i < 3; i++) begin
      prod_r[i]      <= prod_nxt[i];
      ab_r[i]        <= ab_nxt[i];
      lp_r[i]        <= lp_nxt[i];
      shade_r[i]     <= shade_nxt[i];
      out_color_r[i] <= out_color_nxt[i];
    end
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.clearing = (state_r == S_CLEAR);

  assign out_tvalid  = out_valid_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_red     = out_color_r[0];
  assign out_green   = out_color_r[1];
  assign out_blue    = out_color_r[2];
  assign out_last    = out_last_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR) && (clr_addr_r == '0))
    else $error("reset did not start the clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) && (clr_addr_r == AW'(STORE_SIZE - 1)) |=> state_r == S_IDLE)
    else $error("clearing pass did not end after the last entry");

  a_test_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> ($past(state_r) == S_IDLE) && $past(ram_re))
    else $error("depth test without a preceding store read");

  a_block_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load && last_pix |=> (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("final pixel of a block not flagged");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the depth-tested Lambert block fill unit. Clear
// and fragment words go in through the input stream, while a local model of
// the depth store and the shading math predicts every pixel word. Each pixel
// word is checked field by field. The run covers directed corner cases,
// register extremes, random phases with random idling on both streams, and
// one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import zblf_pkg::*;

  localparam int RW            = DEF_RECT_W;
  localparam int RH            = DEF_RECT_H;
  localparam int CELLS         = DEF_MAX_GRID_WIDTH * DEF_MAX_GRID_HEIGHT;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 50000;
  localparam longint LIGHT_FLOOR = longint'(BRIGHT_MIN);

  typedef struct packed {
    logic               kind;
    logic signed [7:0]  cell_x;
    logic signed [7:0]  cell_y;
    logic signed [16:0] depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         albedo_red;
    logic [7:0]         albedo_green;
    logic [7:0]         albedo_blue;
  } frag_t;

  typedef struct packed {
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // cell_x, cell_y, depth, normal_x, normal_y, normal_z,
  // albedo_red, albedo_green, albedo_blue, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  // kind
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // pixel_x, pixel_y, red, green, blue, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  cfg_t               shade_cfg = CFG_RESET;
  logic [DEPTH_W-1:0] cell_depth [CELLS];
  pixel_t             pending_pixels [$];
  pixel_t             seen_exp;
  int                 n_errors     = 0;
  int                 quiet_cycles = 0;
  bit                 tx_steady    = 1'b0;
  bit                 rx_steady    = 1'b0;
  int                 rx_hold      = 0;
  int                 rx_left      = 0;
  int                 rx_pick;

  zbuffer_lambert_block_fill_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic int eff_width();
    return (shade_cfg.grid_width > DEF_MAX_GRID_WIDTH) ? DEF_MAX_GRID_WIDTH
                                                       : int'(shade_cfg.grid_width);
  endfunction

  function automatic int eff_height();
    return (shade_cfg.grid_height > DEF_MAX_GRID_HEIGHT) ? DEF_MAX_GRID_HEIGHT
                                                         : int'(shade_cfg.grid_height);
  endfunction

  function automatic logic [7:0] shade_channel(input logic [7:0] albedo,
                                               input longint unsigned bright,
                                               input logic [9:0] strength);
    longint unsigned c;
    c = ({56'd0, albedo} * bright * {54'd0, strength}) >> 36;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  function automatic void shade_fragment(input frag_t f);
    int         gw, gh, cx, cy, z, idx, i, j;
    longint     dot, bright;
    logic [7:0] r, g, b;
    pixel_t     p;
    if (f.kind == KIND_CLEAR) begin
      foreach (cell_depth[k]) cell_depth[k] = FULL_SCALE;
      return;
    end
    gw = eff_width();
    gh = eff_height();
    cx = $signed(f.cell_x);
    cy = $signed(f.cell_y);
    z  = $signed(f.depth);
    if (cx < 0 || cy < 0 || cx >= gw || cy >= gh) return;
    idx = cy * gw + cx;
    if (z < 0 || z >= int'(cell_depth[idx])) return;
    cell_depth[idx] = z[15:0];
    dot = longint'($signed(f.normal_x)) * longint'($signed(shade_cfg.light_dir_x))
        + longint'($signed(f.normal_y)) * longint'($signed(shade_cfg.light_dir_y))
        + longint'($signed(f.normal_z)) * longint'($signed(shade_cfg.light_dir_z));
    bright = -dot;
    if (bright < LIGHT_FLOOR) bright = LIGHT_FLOOR;
    r = shade_channel(f.albedo_red, bright, shade_cfg.light_red);
    g = shade_channel(f.albedo_green, bright, shade_cfg.light_green);
    b = shade_channel(f.albedo_blue, bright, shade_cfg.light_blue);
    for (i = 0; i < RH; i++) begin
      for (j = 0; j < RW; j++) begin
        p.px    = 10'(cx * RW + j);
        p.py    = 10'(cy * RH + i);
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.last  = (i == RH - 1 && j == RW - 1);
        pending_pixels.push_back(p);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frag_t make_frag(input int cx, cy, z, nx, ny, nz, ar, ag, ab);
    frag_t f;
    f.kind         = KIND_FRAG;
    f.cell_x       = cx[7:0];
    f.cell_y       = cy[7:0];
    f.depth        = z[16:0];
    f.normal_x     = nx[15:0];
    f.normal_y     = ny[15:0];
    f.normal_z     = nz[15:0];
    f.albedo_red   = ar[7:0];
    f.albedo_green = ag[7:0];
    f.albedo_blue  = ab[7:0];
    return f;
  endfunction

  function automatic frag_t noise_word(input logic kind);
    logic [127:0] bits;
    frag_t        f;
    bits   = {$urandom, $urandom, $urandom, $urandom};
    f      = bits[$bits(frag_t)-1:0];
    f.kind = kind;
    return f;
  endfunction

  function automatic frag_t random_fragment();
    int gw, gh;
    gw = eff_width();
    gh = eff_height();
    return make_frag((gw > 0) ? $urandom_range(0, gw - 1) : $urandom_range(0, 127),
                     (gh > 0) ? $urandom_range(0, gh - 1) : $urandom_range(0, 127),
                     $urandom_range(0, 65535),
                     int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384,
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
  endfunction

  task automatic send_word(input frag_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f.kind;
    in_tdata  <= IN_TDATA_W'({f.albedo_blue, f.albedo_green, f.albedo_red,
                              f.normal_z, f.normal_y, f.normal_x,
                              f.depth, f.cell_y, f.cell_x});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shade_fragment(f);
  endtask

  // Sends a fragment that is sure to win the depth test, so that the pixel
  // words it causes mark the point where all earlier words are done.
  task automatic send_passing_fragment();
    int    gw, gh, start, k, idx, found;
    frag_t f;
    gw    = eff_width();
    gh    = eff_height();
    found = -1;
    if (gw == 0 || gh == 0) return;
    start = $urandom_range(0, gw * gh - 1);
    for (k = 0; k < gw * gh && found < 0; k++) begin
      idx = (start + k) % (gw * gh);
      if (cell_depth[idx] != 0) found = idx;
    end
    if (found < 0) return;
    f        = random_fragment();
    f.cell_x = 8'(found % gw);
    f.cell_y = 8'(found / gw);
    f.depth  = 17'($urandom_range(0, int'(cell_depth[found]) - 1));
    send_word(f);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  shade_cfg.grid_width  = val[7:0];
      REG_GRID_HEIGHT: shade_cfg.grid_height = val[7:0];
      REG_LIGHT_DIR_X: shade_cfg.light_dir_x = val[15:0];
      REG_LIGHT_DIR_Y: shade_cfg.light_dir_y = val[15:0];
      REG_LIGHT_DIR_Z: shade_cfg.light_dir_z = val[15:0];
      REG_LIGHT_RED:   shade_cfg.light_red   = val[9:0];
      REG_LIGHT_GREEN: shade_cfg.light_green = val[9:0];
      REG_LIGHT_BLUE:  shade_cfg.light_blue  = val[9:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_word(make_frag(0, 0, 1000, 0, 0, -16384, 255, 128, 0));
    send_word(make_frag(0, 0, 1000, 0, 0, -16384, 7, 7, 7));
    send_word(make_frag(0, 0, 1001, 100, 100, -16384, 7, 7, 7));
    send_word(make_frag(0, 0, 0, 0, 0, -16384, 1, 2, 3));
    send_word(make_frag(127, 127, 65534, 0, 0, -32768, 255, 255, 255));
    send_word(make_frag(127, 126, 65535, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(-1, 5, 10, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(5, -1, 10, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(-128, 0, 10, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(0, -128, 10, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(3, 4, -1, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(3, 4, -65536, 0, 0, -16384, 9, 9, 9));
    send_word(make_frag(3, 4, 40000, 0, 0, 32767, 255, 255, 255));
    send_word(make_frag(10, 20, 50000, -32768, 32767, -12000, 1, 1, 1));
    send_word(make_frag(64, 9, 30000, 16384, -16384, 16384, 200, 100, 50));
    send_word(noise_word(KIND_CLEAR));
    send_word(make_frag(0, 0, 65534, 0, 0, -16384, 255, 0, 255));
    send_word(make_frag(127, 127, 65534, 0, 0, -16384, 0, 255, 0));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_GRID_WIDTH, 32'd0);
    send_word(make_frag(0, 0, 5, 0, 0, -16384, 50, 50, 50));
    send_word(make_frag(5, 5, 5, 0, 0, -16384, 50, 50, 50));
    wait_idle();
    write_reg(REG_GRID_WIDTH, 32'd128);
    write_reg(REG_GRID_HEIGHT, 32'd0);
    send_word(make_frag(0, 0, 5, 0, 0, -16384, 50, 50, 50));
    send_word(make_frag(7, 3, 5, 0, 0, -16384, 50, 50, 50));
    wait_idle();
    write_reg(REG_GRID_WIDTH, 32'd255);
    write_reg(REG_GRID_HEIGHT, 32'd200);
    write_reg(REG_LIGHT_DIR_X, 32'h0000_8000);
    write_reg(REG_LIGHT_DIR_Y, 32'h0000_7FFF);
    write_reg(REG_LIGHT_DIR_Z, 32'hFFFF_C000);
    write_reg(REG_LIGHT_RED, 32'd0);
    write_reg(REG_LIGHT_GREEN, 32'd1023);
    write_reg(REG_LIGHT_BLUE, 32'd1);
    send_word(make_frag(127, 127, 100, 32767, -32768, 16384, 255, 255, 255));
    send_word(make_frag(127, 0, 200, 16384, -16384, 16384, 128, 128, 255));
    send_word(make_frag(0, 127, 300, 0, 0, 0, 255, 255, 255));
    send_word(make_frag(126, 3, 400, -32768, 32767, 0, 255, 255, 255));
    wait_idle();
    write_reg(REG_GRID_WIDTH, 32'hFFFF_FF01);
    write_reg(REG_GRID_HEIGHT, 32'd1);
    write_reg(REG_LIGHT_DIR_X, 32'd16384);
    write_reg(REG_LIGHT_DIR_Y, 32'd0);
    write_reg(REG_LIGHT_DIR_Z, 32'd0);
    write_reg(REG_LIGHT_RED, 32'd256);
    write_reg(REG_LIGHT_GREEN, 32'd512);
    write_reg(REG_LIGHT_BLUE, 32'd768);
    send_word(make_frag(0, 0, 60000, -16384, 0, 0, 200, 150, 100));
    send_word(make_frag(0, 0, 60000, -16384, 0, 0, 200, 150, 100));
    send_word(make_frag(1, 0, 10, -16384, 0, 0, 200, 150, 100));
    send_word(make_frag(0, 1, 10, -16384, 0, 0, 200, 150, 100));
    send_word(make_frag(0, 0, 10, -8000, 0, 0, 255, 255, 255));
    wait_idle();
  endtask

  task automatic test_random();
    int phase, k;
    for (phase = 0; phase < 4; phase++) begin
      write_reg(REG_GRID_WIDTH, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6)
                                                           : $urandom_range(1, 255));
      write_reg(REG_GRID_HEIGHT, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6)
                                                            : $urandom_range(1, 255));
      write_reg(REG_LIGHT_DIR_X, $urandom_range(0, 1) ? $urandom_range(0, 32768) - 16384
                                                      : $urandom);
      write_reg(REG_LIGHT_DIR_Y, $urandom_range(0, 1) ? $urandom_range(0, 32768) - 16384
                                                      : $urandom);
      write_reg(REG_LIGHT_DIR_Z, $urandom_range(0, 1) ? $urandom_range(0, 32768) - 16384
                                                      : $urandom);
      write_reg(REG_LIGHT_RED, $urandom_range(0, 1023));
      write_reg(REG_LIGHT_GREEN, $urandom_range(0, 1023));
      write_reg(REG_LIGHT_BLUE, $urandom_range(0, 1023));
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      if (phase % 2 == 0) send_word(noise_word(KIND_CLEAR));
      for (k = 0; k < 15; k++) begin
        if ($urandom_range(0, 99) < 80) send_word(random_fragment());
        else send_word(noise_word(KIND_FRAG));
      end
      send_passing_fragment();
      wait_idle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    int k;
    write_reg(REG_GRID_WIDTH, 32'd128);
    write_reg(REG_GRID_HEIGHT, 32'd128);
    tx_steady = 1'b1;
    rx_hold   = 400;
    for (k = 0; k < 10; k++) send_passing_fragment();
    tx_steady = 1'b0;
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_left = 0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_steady || rx_pick < 60) begin
        out_tready <= 1'b1;
        rx_left = $urandom_range(0, 15);
      end else if (rx_pick < 92) begin
        out_tready <= 1'b0;
        rx_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        rx_left = $urandom_range(8, 40);
      end
    end
  end

  function automatic void check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected pixel word, expected none, got %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        seen_exp = pending_pixels.pop_front();
        check_field("pixel_x", seen_exp.px, out_tdata[9:0]);
        check_field("pixel_y", seen_exp.py, out_tdata[19:10]);
        check_field("red", seen_exp.red, out_tdata[27:20]);
        check_field("green", seen_exp.green, out_tdata[35:28]);
        check_field("blue", seen_exp.blue, out_tdata[43:36]);
        check_field("last", seen_exp.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    foreach (cell_depth[i]) cell_depth[i] = FULL_SCALE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
